### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk, masked while arst_n is low.
`define SCFR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every rising edge of clk, reset included.
`define SCFR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/scfr_pkg.sv
// ----------------------------------------------------------------------------
// scfr_pkg
// Types and constants of the serial command frame responder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scfr_pkg;

	localparam int FRAME_LENGTH = 6;

	localparam logic [7:0] START_MARK         = 8'hF1;
	localparam logic [7:0] END_MARK           = 8'hF2;
	localparam logic [7:0] CMD_WRITE_PORT     = 8'h03;
	localparam logic [7:0] CMD_READ_PORT      = 8'h04;
	localparam logic [7:0] CMD_READ_SAMPLE    = 8'h08;
	localparam logic [7:0] CMD_SELECT_CHANNEL = 8'h09;
	localparam logic [7:0] BASE_RESET         = 8'h23;
	localparam logic [7:0] TAIL_WRITE         = 8'h01;
	localparam logic [7:0] TAIL_NONE          = 8'h00;
	localparam logic [2:0] SCAN_RESET         = 3'd1;

	// Frame byte positions, shared by the parser and the serializer
	localparam logic [2:0] POS_START = 3'd0;
	localparam logic [2:0] POS_ADDR  = 3'd1;
	localparam logic [2:0] POS_KIND  = 3'd2;
	localparam logic [2:0] POS_DATA  = 3'd3;
	localparam logic [2:0] POS_TAIL  = 3'd4;
	localparam logic [2:0] POS_LAST  = 3'(FRAME_LENGTH - 1);
	localparam logic [2:0] POS_END   = 3'(FRAME_LENGTH);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef struct packed {
		logic [7:0] addr;
		logic [7:0] kind_byte;
		logic [7:0] data_byte;
		logic [7:0] tail_byte;
		logic       pin_drive;
		logic [2:0] scan;
	} reply_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

### rtl/core/scfr_front.sv
// ----------------------------------------------------------------------------
// scfr_front
// Frame parser and command executor: stores samples, collects frames,
// applies commands and queues one reply descriptor per answered frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scfr_front #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                mode,
	input  logic [7:0]          rx_byte,
	input  logic [2:0]          sample_channel,
	input  logic [11:0]         sample_value,
	input  logic                pin_level,
	input  logic                cfg_write,
	input  logic [7:0]          cfg_data,
	output logic                push,
	output scfr_pkg::reply_t    push_data
);
	import scfr_pkg::*;

	localparam int         CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [7:0] NUM_CH_B = 8'(NUM_CHANNELS);

	logic [7:0]  base_q;
	logic        in_frame_q;
	logic [2:0]  pos_q;
	logic [7:0]  addr_q;
	logic [7:0]  cmd_q;
	logic [11:0] samples_q [NUM_CHANNELS];
	logic [7:0]  last_reply_q;
	logic        pin_q;
	logic [2:0]  sel_q;

	logic [2:0]  pos_nxt;
	logic        frame_done;
	logic [7:0]  idx;
	logic        hit;
	logic [7:0]  sample_reply;
	logic        pin_nxt;

	assign pos_nxt    = pos_q + 3'd1;
	assign frame_done = accept && !mode && in_frame_q && (pos_nxt == POS_END)
		&& (rx_byte == END_MARK);
	assign idx        = addr_q - base_q;
	assign hit        = idx < NUM_CH_B;

	always_comb begin
		sample_reply = last_reply_q;
		pin_nxt      = pin_q;
		if (hit) begin
			sample_reply = samples_q[idx[CH_W-1:0]][11:4];
			if (idx == 8'd0) begin
				pin_nxt = 1'b1;
			end else if (idx == 8'd1) begin
				pin_nxt = 1'b0;
			end
		end
	end

	always_comb begin
		push                = 1'b0;
		push_data.addr      = addr_q;
		push_data.kind_byte = CMD_READ_PORT;
		push_data.data_byte = {7'd0, pin_level};
		push_data.tail_byte = TAIL_WRITE;
		push_data.pin_drive = pin_q;
		push_data.scan      = sel_q;
		unique case (cmd_q)
			CMD_WRITE_PORT: begin
				push = frame_done;
			end
			CMD_READ_PORT: begin
				push                = frame_done;
				push_data.data_byte = CMD_WRITE_PORT;
				push_data.tail_byte = TAIL_NONE;
			end
			CMD_READ_SAMPLE: begin
				push                = frame_done;
				push_data.kind_byte = CMD_READ_SAMPLE;
				push_data.data_byte = sample_reply;
				push_data.tail_byte = TAIL_NONE;
				push_data.pin_drive = pin_nxt;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= BASE_RESET;
			in_frame_q   <= 1'b0;
			pos_q        <= 3'd0;
			last_reply_q <= 8'd0;
			pin_q        <= 1'b0;
			sel_q        <= SCAN_RESET;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				samples_q[i] <= 12'd0;
			end
		end else begin
			if (cfg_write) begin
				base_q <= cfg_data;
			end
			if (accept && mode) begin
				if ({5'd0, sample_channel} < NUM_CH_B) begin
					samples_q[CH_W'(sample_channel)] <= sample_value;
				end
			end else if (accept && !in_frame_q) begin
				if (rx_byte == START_MARK) begin
					in_frame_q <= 1'b1;
					pos_q      <= 3'd1;
				end
			end else if (accept) begin
				if (pos_nxt == POS_END) begin
					in_frame_q <= 1'b0;
					pos_q      <= 3'd0;
				end else begin
					pos_q <= pos_nxt;
				end
				// apply command side effects on a well-closed frame
				if (frame_done && cmd_q == CMD_READ_SAMPLE) begin
					last_reply_q <= sample_reply;
					pin_q        <= pin_nxt;
				end
				if (frame_done && cmd_q == CMD_SELECT_CHANNEL && hit) begin
					sel_q <= idx[2:0];
				end
			end
		end
	end

	// frame field bytes need no reset
	always_ff @(posedge clk) begin
		if (accept && !mode && in_frame_q) begin
			if (pos_nxt == 3'd2) begin
				addr_q <= rx_byte;
			end
			if (pos_nxt == 3'd3) begin
				cmd_q <= rx_byte;
			end
		end
	end

endmodule

### rtl/core/scfr_queue.sv
// ----------------------------------------------------------------------------
// scfr_queue
// Short reply descriptor queue between the parser and the serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scfr_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  scfr_pkg::reply_t        push_data,
	input  logic                    pop,
	output scfr_pkg::reply_t        head,
	output scfr_pkg::queue_status_t status
);
	import scfr_pkg::*;

	reply_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign head         = entry_q[rd_ptr_q];
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/core/scfr_back.sv
// ----------------------------------------------------------------------------
// scfr_back
// Reply serializer: turns one queued descriptor into six output beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scfr_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  scfr_pkg::reply_t        head,
	input  scfr_pkg::queue_status_t status,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [7:0]              tx_byte,
	output logic                    last_byte,
	output logic                    pin_drive,
	output logic [2:0]              scan_channel
);
	import scfr_pkg::*;

	reply_t     cur_q;
	logic       busy_q;
	logic [2:0] beat_q;
	logic       beat_done;

	assign beat_done = busy_q && out_ready;
	assign pop       = !status.empty && (!busy_q || (beat_done && beat_q == POS_LAST));

	assign out_valid    = busy_q;
	assign last_byte    = (beat_q == POS_LAST);
	assign pin_drive    = cur_q.pin_drive;
	assign scan_channel = cur_q.scan;

	always_comb begin
		unique case (beat_q)
			POS_START: tx_byte = START_MARK;
			POS_ADDR:  tx_byte = cur_q.addr;
			POS_KIND:  tx_byte = cur_q.kind_byte;
			POS_DATA:  tx_byte = cur_q.data_byte;
			POS_TAIL:  tx_byte = cur_q.tail_byte;
			default:   tx_byte = END_MARK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			beat_q <= POS_START;
		end else if (pop) begin
			busy_q <= 1'b1;
			beat_q <= POS_START;
		end else if (beat_done) begin
			if (beat_q == POS_LAST) begin
				busy_q <= 1'b0;
				beat_q <= POS_START;
			end else begin
				beat_q <= beat_q + 3'd1;
			end
		end
	end

	// descriptor holds while its beats go out
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

endmodule

### rtl/core/serial_command_frame_responder.sv
// ----------------------------------------------------------------------------
// serial_command_frame_responder
// Collects six-byte command frames from serial bytes and answers them with
// six-byte reply frames; also stores converter samples per channel.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | sink      | in_valid / in_ready  | mode rx_byte sample_channel sample_value pin_level
// out     | source    | out_valid / out_ready| tx_byte last_byte pin_drive scan_channel
// cfg     | sink      | cfg_valid / cfg_ready| cfg_data (channel base address)
//
// An input beat is taken every cycle while the two-entry reply queue has room.
// A command is applied in the cycle its closing byte is taken; each reply then
// leaves as six beats, one per cycle while out_ready is high, from the
// serializer register. Input stalls only when two replies wait behind the one
// going out. Reset clears samples, control state and the queue at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module serial_command_frame_responder #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [7:0]  rx_byte,
	input  logic [2:0]  sample_channel,
	input  logic [11:0] sample_value,
	input  logic        pin_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  tx_byte,
	output logic        last_byte,
	output logic        pin_drive,
	output logic [2:0]  scan_channel,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import scfr_pkg::*;

	logic          accept;
	logic          push;
	logic          pop;
	reply_t        push_data;
	reply_t        head;
	queue_status_t q_stat;

	assign in_ready  = !q_stat.full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	scfr_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.mode          (mode),
		.rx_byte       (rx_byte),
		.sample_channel(sample_channel),
		.sample_value  (sample_value),
		.pin_level     (pin_level),
		.cfg_write     (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.push          (push),
		.push_data     (push_data)
	);

	scfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.status   (q_stat)
	);

	scfr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.status      (q_stat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.tx_byte     (tx_byte),
		.last_byte   (last_byte),
		.pin_drive   (pin_drive),
		.scan_channel(scan_channel)
	);

	`SCFR_ASSERT(a_sample_no_reply, (accept && mode |-> !push), "sample update queued a reply")
	`SCFR_ASSERT(a_frame_contiguous, (out_valid && out_ready && !last_byte |=> out_valid), "reply frame broken up")
	`SCFR_ASSERT(a_idle_after_last, (out_valid && out_ready && last_byte && q_stat.empty && !push |=> !out_valid), "beat shown with nothing queued")
	`SCFR_ASSERT_ALWAYS(a_reset_quiet, (!arst_n |-> !out_valid), "output valid during reset")

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for serial_command_frame_responder. It drives serial
// bytes and sample updates through the input channel with random gaps. A
// behavioral copy of the frame parser and command logic predicts every reply
// beat, and each beat taken from the output channel is checked against it.
// The run covers directed frames, output back-pressure that fills the reply
// queue, and random traffic under several channel base addresses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import scfr_pkg::*;

	localparam int CHANNELS       = 8;
	localparam int RESET_CYCLES   = 10;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 300;
	// longest quiet stretch is the receiver hold plus a reply of stalled beats
	localparam int IDLE_LIMIT     = 3000;
	localparam logic [7:0] READ_PORT_DATA = 8'h03;

	typedef struct packed {
		logic [7:0] tx;
		logic       last;
		logic       pin;
		logic [2:0] scan;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [7:0]  rx_byte;
	logic [2:0]  sample_channel;
	logic [11:0] sample_value;
	logic        pin_level;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  tx_byte;
	logic        last_byte;
	logic        pin_drive;
	logic [2:0]  scan_channel;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	// predicted responder state
	logic [7:0]  base_addr;
	bit          frame_open;
	logic [2:0]  frame_pos;
	logic [7:0]  frame_bytes [4];
	logic [11:0] samples [CHANNELS];
	logic [7:0]  last_reply;
	logic        pin_state;
	logic [2:0]  scan_sel;

	beat_t       reply_q [$];
	int          error_count = 0;
	int unsigned items_sent = 0;
	int unsigned idle_cycles = 0;
	int unsigned sink_hold = 0;
	bit          src_steady = 1'b0;
	bit          sink_steady = 1'b0;

	serial_command_frame_responder #(
		.NUM_CHANNELS(CHANNELS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.rx_byte(rx_byte),
		.sample_channel(sample_channel),
		.sample_value(sample_value),
		.pin_level(pin_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tx_byte(tx_byte),
		.last_byte(last_byte),
		.pin_drive(pin_drive),
		.scan_channel(scan_channel),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void reset_prediction();
		base_addr = BASE_RESET;
		frame_open = 1'b0;
		frame_pos = 3'd0;
		foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
		foreach (samples[i]) samples[i] = 12'h000;
		last_reply = 8'h00;
		pin_state = 1'b0;
		scan_sel = SCAN_RESET;
	endfunction

	// Advance the parser by one accepted item and queue any reply beats.
	function automatic void predict_item(input logic m, input logic [7:0] b,
			input logic [2:0] ch, input logic [11:0] v, input logic p);
		logic [7:0] reply [FRAME_LENGTH];
		logic [7:0] idx;
		logic [7:0] cmd;
		bit         answer;
		beat_t      bt;
		if (m) begin
			samples[ch] = v;
			return;
		end
		if (!frame_open) begin
			if (b == START_MARK) begin
				frame_open = 1'b1;
				frame_pos = 3'd1;
			end
			return;
		end
		frame_pos = frame_pos + 3'd1;
		if (frame_pos < FRAME_LENGTH) begin
			if (frame_pos >= 3'd2) frame_bytes[frame_pos - 3'd2] = b;
			return;
		end
		frame_open = 1'b0;
		frame_pos = 3'd0;
		if (b != END_MARK) return;

		idx = frame_bytes[0] - base_addr;
		cmd = frame_bytes[1];
		answer = 1'b1;
		reply[0] = START_MARK;
		reply[1] = frame_bytes[0];
		reply[5] = END_MARK;
		case (cmd)
			CMD_WRITE_PORT: begin
				reply[2] = CMD_READ_PORT;
				reply[3] = {7'd0, p};
				reply[4] = TAIL_WRITE;
			end
			CMD_READ_PORT: begin
				reply[2] = CMD_READ_PORT;
				reply[3] = READ_PORT_DATA;
				reply[4] = TAIL_NONE;
			end
			CMD_READ_SAMPLE: begin
				if (idx < CHANNELS) begin
					if (idx == 8'd0) pin_state = 1'b1;
					else if (idx == 8'd1) pin_state = 1'b0;
					last_reply = samples[idx[2:0]][11:4];
				end
				reply[2] = CMD_READ_SAMPLE;
				reply[3] = last_reply;
				reply[4] = TAIL_NONE;
			end
			default: begin
				if (cmd == CMD_SELECT_CHANNEL && idx < CHANNELS) scan_sel = idx[2:0];
				answer = 1'b0;
			end
		endcase
		if (answer) begin
			for (int k = 0; k < FRAME_LENGTH; k++) begin
				bt.tx = reply[k];
				bt.last = (k == FRAME_LENGTH - 1);
				bt.pin = pin_state;
				bt.scan = scan_sel;
				reply_q.push_back(bt);
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Offer one item; returns at the edge that takes it, with valid still high.
	task automatic send_item(input logic m, input logic [7:0] b, input logic [2:0] ch,
			input logic [11:0] v, input logic p);
		int unsigned gap;
		gap = src_steady ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		rx_byte <= b;
		sample_channel <= ch;
		sample_value <= v;
		pin_level <= p;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		predict_item(m, b, ch, v, p);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic p);
		send_item(1'b0, b, 3'($urandom), 12'($urandom), p);
	endtask

	task automatic send_sample(input logic [2:0] ch, input logic [11:0] v);
		send_item(1'b1, 8'($urandom), ch, v, 1'($urandom));
	endtask

	task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
			input logic [7:0] info, input logic [7:0] spare, input logic [7:0] closing,
			input logic closing_pin);
		send_byte(START_MARK, 1'($urandom));
		send_byte(addr, 1'($urandom));
		send_byte(cmd, 1'($urandom));
		send_byte(info, 1'($urandom));
		send_byte(spare, 1'($urandom));
		send_byte(closing, closing_pin);
	endtask

	// Close any open frame, drop valid and wait until every reply has left.
	task automatic settle_block();
		while (frame_open) send_byte(8'h00, 1'($urandom));
		in_valid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		base_addr = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed_frames();
		send_sample(3'd0, 12'hFFF);
		send_sample(3'd7, 12'h000);
		// bytes outside a frame are dropped
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_frame(BASE_RESET, CMD_READ_SAMPLE, 8'h00, 8'hFF, END_MARK, 1'b0);
		// start mark inside a frame is plain data
		send_frame(BASE_RESET + 8'd1, CMD_WRITE_PORT, START_MARK, 8'h55, END_MARK, 1'b1);
		send_frame(BASE_RESET, CMD_READ_PORT, 8'hAA, 8'h00, 8'h00, 1'b0);
		send_frame(BASE_RESET + 8'd7, CMD_SELECT_CHANNEL, 8'h00, 8'h00, END_MARK, 1'b0);
	endtask

	task automatic test_output_backpressure();
		settle_block();
		sink_hold = HOLD_CYCLES;
		src_steady = 1'b1;
		repeat (5) send_frame(base_addr, CMD_READ_PORT, 8'($urandom), 8'($urandom),
			END_MARK, 1'($urandom));
		// sender waits for every reply before going on
		settle_block();
		src_steady = 1'b0;
		send_frame(base_addr + 8'd1, CMD_READ_SAMPLE, 8'h00, 8'h00, END_MARK, 1'b0);
	endtask

	task automatic test_random_traffic(input logic [7:0] base, input int unsigned count);
		int unsigned stop_at;
		logic [7:0]  addr;
		logic [7:0]  cmd;
		logic [7:0]  closing;
		settle_block();
		write_base(base);
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 15) == 0) src_steady = !src_steady;
			if ($urandom_range(0, 15) == 0) sink_steady = !sink_steady;
			addr = ($urandom_range(0, 3) == 0) ? 8'($urandom)
				: base_addr + 8'($urandom_range(0, CHANNELS - 1));
			case ($urandom_range(0, 5))
				0: cmd = CMD_WRITE_PORT;
				1: cmd = CMD_READ_PORT;
				2, 3: cmd = CMD_READ_SAMPLE;
				4: cmd = CMD_SELECT_CHANNEL;
				default: cmd = 8'($urandom);
			endcase
			case ($urandom_range(0, 9))
				0: send_sample(3'($urandom), 12'($urandom));
				1: send_byte(8'($urandom), 1'($urandom));
				2: begin
					// broken frame: a start and a few bytes, left open
					send_byte(START_MARK, 1'($urandom));
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'($urandom));
				end
				3: begin
					closing = 8'($urandom);
					if (closing == END_MARK) closing = ~closing;
					send_frame(addr, cmd, 8'($urandom), 8'($urandom), closing, 1'($urandom));
				end
				default: send_frame(addr, cmd, 8'($urandom), 8'($urandom), END_MARK,
					1'($urandom));
			endcase
		end
	endtask

	// take reply beats with random stalls, plus any hold-off the tests ask for
	initial begin : reply_sink
		int unsigned pause;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			pause = sink_steady ? 0 : $urandom_range(0, 8);
			pause += sink_hold;
			sink_hold = 0;
			if (pause != 0) begin
				out_ready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (!out_valid);
		end
	end

	always @(negedge clk) begin : reply_checker
		beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (reply_q.size() == 0) begin
				report_mismatch("beat with no reply pending", tx_byte, 0);
			end else begin
				want = reply_q.pop_front();
				if (tx_byte !== want.tx) report_mismatch("tx_byte", tx_byte, want.tx);
				if (last_byte !== want.last) report_mismatch("last_byte", last_byte, want.last);
				if (pin_drive !== want.pin) report_mismatch("pin_drive", pin_drive, want.pin);
				if (scan_channel !== want.scan)
					report_mismatch("scan_channel", scan_channel, want.scan);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = 1'b0;
		rx_byte = 8'h00;
		sample_channel = 3'd0;
		sample_value = 12'h000;
		pin_level = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 8'h00;
		reset_prediction();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_output_backpressure();
		test_random_traffic(8'h00, 10);
		test_random_traffic(8'hFF, 10);
		test_random_traffic(8'($urandom), 10);
		test_random_traffic(BASE_RESET, 6);

		settle_block();
		repeat (16) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/scfr_pkg.sv
rtl/core/scfr_front.sv
rtl/core/scfr_queue.sv
rtl/core/scfr_back.sv
rtl/core/serial_command_frame_responder.sv
sim/tb.sv
